// ----- hdl/gpem_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpem_pkg
// Shared types and constants of the gray Prewitt edge magnitude block.
// ----------------------------------------------------------------------------
package gpem_pkg;

    localparam int CFG_W         = 12;
    localparam int PIX_W         = 8;
    localparam int POS_W         = 11;
    localparam int GRAD_W        = 11;
    localparam int SQ_W          = 21;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT    = 2048;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [CFG_W-1:0] BAND_RST   = 12'd480;

    // floor(a/3) == (a*683) >> 11 for a below 1024
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;

    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FRAME_WIDTH  = 2'd0;
    localparam cfg_idx_t CFG_FRAME_HEIGHT = 2'd1;
    localparam cfg_idx_t CFG_BAND_ROWS    = 2'd2;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_LOAD,
        CTL_START,
        CTL_WAIT,
        CTL_OUT
    } ctl_state_t;

    typedef enum logic [2:0] {
        MAG_IDLE,
        MAG_FIX,
        MAG_SQX,
        MAG_SQY,
        MAG_ROOT
    } mag_state_t;

    // gradient pair handed to the magnitude unit; gx and gy are two's complement
    typedef struct packed {
        logic [GRAD_W-1:0] gx;
        logic [GRAD_W-1:0] gy;
        logic              fix_x;
        logic              fix_y;
    } mag_req_t;

endpackage

// ----- hdl/gray_prewitt_edge_magnitude.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_prewitt_edge_magnitude
// Gray conversion, two-line buffer and 3x3 Prewitt edge magnitude.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item that gives no result takes the
// transfer and the read-modify-write of the line memory, which holds the two
// previous rows of a column in one 16-bit word. Each result also passes the
// magnitude unit: remainder step, two squares through one multiplier and an
// 8-step square root; a sum of squares at or above 65536 ends the root at its
// first step, clamping the value to 255. A result then waits in
// the output register until it is transferred. Results of row r-1 come while
// row r streams in; after the last pixel of a frame, frame_width flush items
// (kind = 1) drain the last row. A flush that arrives before the frame is
// complete, or a pixel while the last row awaits draining, is accepted and
// dropped. A register write restarts the frame at row 0, column 0. The line
// memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module gray_prewitt_edge_magnitude
#(
    parameter int MAX_WIDTH = gpem_pkg::MAX_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  gpem_pkg::cfg_idx_t              cfg_index,
    input  logic [gpem_pkg::CFG_W-1:0]      cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [gpem_pkg::PIX_W-1:0]      blue,
    input  logic [gpem_pkg::PIX_W-1:0]      green,
    input  logic [gpem_pkg::PIX_W-1:0]      red,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      edge_value,
    output logic [gpem_pkg::POS_W-1:0]      out_row,
    output logic [gpem_pkg::POS_W-1:0]      out_col,
    output logic                            frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = gpem_pkg::CFG_W;
    localparam int GW = gpem_pkg::GRAD_W;

    gpem_pkg::ctl_state_t state_reg, state_next;

    logic [gpem_pkg::CFG_W-1:0] width_cfg_reg;
    logic [gpem_pkg::CFG_W-1:0] height_cfg_reg;
    logic [gpem_pkg::CFG_W-1:0] band_cfg_reg;

    logic [RW-1:0] row_count_reg;
    logic [CW-1:0] col_count_reg;
    logic [CW-1:0] drain_col_reg;
    logic [RW-1:0] band_pos_reg;

    logic [RW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    logic [7:0]    g_reg;
    logic          last_reg;
    logic [RW-1:0] band_item_reg;
    logic [15:0]   rd_reg;
    logic          sel_b_reg;
    logic          pend_b_reg;

    logic [15:0]   mem [MAX_WIDTH];
    logic [7:0]    win_reg [3][3];

    logic [7:0]                 edge_value_reg;
    logic [gpem_pkg::POS_W-1:0] out_row_reg;
    logic [gpem_pkg::POS_W-1:0] out_col_reg;
    logic                       frame_end_reg;

    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic [RW-1:0] eff_band;
    logic          accept;
    logic          pix_act;
    logic          fl_act;
    logic          act;
    logic [9:0]    rgb_sum;
    logic [19:0]   gray_prod;
    logic [CW-1:0] act_col;
    logic          emit_a;
    logic          emit_b;
    logic          out_xfer;

    logic                 tv;
    logic                 bv;
    logic                 lv;
    logic [7:0]           col_top [3];
    logic [7:0]           col_bot [3];
    logic [9:0]           col_sum [3];
    logic signed [GW-1:0] col_dif [3];
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] gy;
    logic                 fix_x;
    logic                 fix_y;
    logic [CW-1:0]        ocol;
    logic                 fend;

    gpem_pkg::mag_req_t mag_req;
    logic               mag_start;
    logic               mag_done;
    logic [7:0]         mag_value;

    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            eff_w = CW'(1);
        end
        else if (32'(width_cfg_reg) > MAX_WIDTH)
        begin
            eff_w = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CW'(width_cfg_reg);
        end

        if (height_cfg_reg == '0)
        begin
            eff_h = RW'(1);
        end
        else if (32'(height_cfg_reg) > gpem_pkg::MAX_HEIGHT)
        begin
            eff_h = RW'(gpem_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h = height_cfg_reg;
        end

        eff_band = (band_cfg_reg == '0) ? RW'(1) : band_cfg_reg;
    end

    assign in_stall  = (state_reg != gpem_pkg::CTL_IDLE);
    assign accept    = in_valid && !in_stall;
    assign pix_act   = !kind && (row_count_reg < eff_h);
    assign fl_act    = kind && (row_count_reg >= eff_h);
    assign act       = accept && (pix_act || fl_act);
    assign act_col   = kind ? drain_col_reg : col_count_reg;
    assign rgb_sum   = 10'(blue) + 10'(green) + 10'(red);
    assign gray_prod = 20'(rgb_sum) * 20'(gpem_pkg::RECIP3);

    assign emit_a    = (r_reg >= RW'(1)) && (c_reg >= CW'(1));
    assign emit_b    = (r_reg >= RW'(1)) && (c_reg + CW'(1) == eff_w);
    assign out_xfer  = out_valid && !out_stall;
    assign mag_start = (state_reg == gpem_pkg::CTL_START);

    // configuration and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= gpem_pkg::WIDTH_RST;
            height_cfg_reg <= gpem_pkg::HEIGHT_RST;
            band_cfg_reg   <= gpem_pkg::BAND_RST;
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            drain_col_reg  <= '0;
            band_pos_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gpem_pkg::CFG_FRAME_WIDTH:  width_cfg_reg  <= cfg_data;
                gpem_pkg::CFG_FRAME_HEIGHT: height_cfg_reg <= cfg_data;
                gpem_pkg::CFG_BAND_ROWS:    band_cfg_reg   <= cfg_data;
                default:
                begin
                end
            endcase
            if (cfg_index == gpem_pkg::CFG_FRAME_WIDTH ||
                cfg_index == gpem_pkg::CFG_FRAME_HEIGHT ||
                cfg_index == gpem_pkg::CFG_BAND_ROWS)
            begin
                row_count_reg <= '0;
                col_count_reg <= '0;
                drain_col_reg <= '0;
                band_pos_reg  <= '0;
            end
        end
        else if (accept && pix_act)
        begin
            if (col_count_reg + CW'(1) >= eff_w)
            begin
                col_count_reg <= '0;
                row_count_reg <= row_count_reg + RW'(1);
                drain_col_reg <= '0;
                if (row_count_reg == '0)
                begin
                    band_pos_reg <= '0;
                end
                else if (band_pos_reg + RW'(1) >= eff_band)
                begin
                    band_pos_reg <= '0;
                end
                else
                begin
                    band_pos_reg <= band_pos_reg + RW'(1);
                end
            end
            else
            begin
                col_count_reg <= col_count_reg + CW'(1);
            end
        end
        else if (accept && fl_act)
        begin
            if (drain_col_reg + CW'(1) >= eff_w)
            begin
                drain_col_reg <= '0;
                row_count_reg <= '0;
                col_count_reg <= '0;
            end
            else
            begin
                drain_col_reg <= drain_col_reg + CW'(1);
            end
        end
    end

    // line memory: {row r-2, row r-1} per column
    always_ff @(posedge clk)
    begin
        if (act)
        begin
            rd_reg <= mem[act_col[AW-1:0]];
        end
        if (state_reg == gpem_pkg::CTL_LOAD)
        begin
            mem[c_reg[AW-1:0]] <= {rd_reg[7:0], g_reg};
        end
    end

    // item row, column, gray value and band position of the result row, taken before the row counters move
    always_ff @(posedge clk)
    begin
        if (act)
        begin
            r_reg         <= kind ? eff_h : row_count_reg;
            c_reg         <= act_col;
            g_reg         <= kind ? 8'd0 : 8'(gray_prod >> gpem_pkg::RECIP3_SHIFT);
            last_reg      <= kind;
            band_item_reg <= band_pos_reg;
        end
    end

    // 3x3 window, column 2 is the newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else if (state_reg == gpem_pkg::CTL_LOAD)
        begin
            for (int k = 0; k < 2; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[k][j] <= win_reg[k+1][j];
                end
            end
            win_reg[2][0] <= rd_reg[15:8];
            win_reg[2][1] <= rd_reg[7:0];
            win_reg[2][2] <= g_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gpem_pkg::CTL_IDLE;
            sel_b_reg  <= 1'b0;
            pend_b_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gpem_pkg::CTL_LOAD)
            begin
                sel_b_reg  <= !emit_a;
                pend_b_reg <= emit_a && emit_b;
            end
            else if (state_reg == gpem_pkg::CTL_OUT && out_xfer && pend_b_reg)
            begin
                sel_b_reg  <= 1'b1;
                pend_b_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        out_valid  = 1'b0;
        unique case (state_reg)
            gpem_pkg::CTL_IDLE:
            begin
                if (act && !cfg_we)
                begin
                    state_next = gpem_pkg::CTL_LOAD;
                end
            end
            gpem_pkg::CTL_LOAD:
            begin
                state_next = (emit_a || emit_b) ? gpem_pkg::CTL_START : gpem_pkg::CTL_IDLE;
            end
            gpem_pkg::CTL_START:
            begin
                state_next = gpem_pkg::CTL_WAIT;
            end
            gpem_pkg::CTL_WAIT:
            begin
                if (mag_done)
                begin
                    state_next = gpem_pkg::CTL_OUT;
                end
            end
            gpem_pkg::CTL_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = pend_b_reg ? gpem_pkg::CTL_START : gpem_pkg::CTL_IDLE;
                end
            end
            default: state_next = gpem_pkg::CTL_IDLE;
        endcase
    end

    // Prewitt sums; result A is (r-1, c-1), result B is the row's last column
    always_comb
    begin
        tv = (r_reg >= RW'(2));
        bv = (r_reg < eff_h);
        for (int k = 0; k < 3; k++)
        begin
            col_top[k] = tv ? win_reg[k][0] : 8'd0;
            col_bot[k] = bv ? win_reg[k][2] : 8'd0;
            col_sum[k] = 10'(col_top[k]) + 10'(win_reg[k][1]) + 10'(col_bot[k]);
            col_dif[k] = $signed(GW'(col_bot[k])) - $signed(GW'(col_top[k]));
        end

        if (!sel_b_reg)
        begin
            lv    = (c_reg >= CW'(2));
            gx    = $signed(GW'(col_sum[2])) -
                    (lv ? $signed(GW'(col_sum[0])) : GW'(0));
            gy    = (lv ? col_dif[0] : GW'(0)) + col_dif[1] + col_dif[2];
            fix_x = (c_reg == CW'(1));
            ocol  = c_reg - CW'(1);
            fend  = 1'b0;
        end
        else
        begin
            lv    = (c_reg >= CW'(1));
            gx    = GW'(0) - (lv ? $signed(GW'(col_sum[1])) : GW'(0));
            gy    = (lv ? col_dif[1] : GW'(0)) + col_dif[2];
            fix_x = 1'b1;
            ocol  = c_reg;
            fend  = last_reg;
        end

        fix_y = (band_item_reg == '0) || (band_item_reg == eff_band - RW'(1));

        mag_req.gx    = gx;
        mag_req.gy    = gy;
        mag_req.fix_x = fix_x;
        mag_req.fix_y = fix_y;
    end

    gpem_mag u_mag
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mag_start),
        .req   (mag_req),
        .done  (mag_done),
        .value (mag_value)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == gpem_pkg::CTL_WAIT && mag_done)
        begin
            edge_value_reg <= mag_value;
            out_row_reg    <= gpem_pkg::POS_W'(r_reg - RW'(1));
            out_col_reg    <= gpem_pkg::POS_W'(ocol);
            frame_end_reg  <= fend;
        end
    end

    assign edge_value = edge_value_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_end  = frame_end_reg;

endmodule

// ----- hdl/gpem_mag.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpem_mag
// Edge magnitude unit: optional truncating remainder by 3 on each gradient,
// squares through one shared multiplier, then an 8-step integer square root
// clamped to 255.
// ----------------------------------------------------------------------------
module gpem_mag
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  gpem_pkg::mag_req_t req,
    output logic               done,
    output logic [7:0]         value
);

    gpem_pkg::mag_state_t state_reg, state_next;

    logic signed [gpem_pkg::GRAD_W-1:0] gx_reg;
    logic signed [gpem_pkg::GRAD_W-1:0] gy_reg;
    logic                               fix_x_reg;
    logic                               fix_y_reg;
    logic [gpem_pkg::SQ_W-1:0]          sq_reg;
    logic [7:0]                         root_reg;
    logic [2:0]                         bit_reg;
    logic                               done_reg;

    logic signed [gpem_pkg::SQ_W:0]     prod;
    logic [7:0]                         trial;
    logic [15:0]                        trial_sq;
    logic                               big;
    logic                               root_last;

    function automatic logic signed [gpem_pkg::GRAD_W-1:0] rem3
        (input logic signed [gpem_pkg::GRAD_W-1:0] v);
        logic [9:0]                         mag;
        logic [19:0]                        mp;
        logic [9:0]                         quo;
        logic [1:0]                         r;
        logic signed [gpem_pkg::GRAD_W-1:0] rs;
        mag = v[gpem_pkg::GRAD_W-1] ? 10'(-v) : v[9:0];
        mp  = 20'(mag) * 20'(gpem_pkg::RECIP3);
        quo = 10'(mp >> gpem_pkg::RECIP3_SHIFT);
        r   = 2'(mag - 10'(quo * 10'd3));
        rs  = $signed({9'b0, r});
        return v[gpem_pkg::GRAD_W-1] ? -rs : rs;
    endfunction

    assign prod      = (state_reg == gpem_pkg::MAG_SQX) ? gx_reg * gx_reg : gy_reg * gy_reg;
    assign trial     = root_reg | (8'd1 << bit_reg);
    assign trial_sq  = 16'(trial) * 16'(trial);
    assign big       = |sq_reg[gpem_pkg::SQ_W-1:16];
    assign root_last = big || (bit_reg == 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gpem_pkg::MAG_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == gpem_pkg::MAG_ROOT) && root_last;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gpem_pkg::MAG_IDLE:
            begin
                if (start)
                begin
                    state_next = gpem_pkg::MAG_FIX;
                end
            end
            gpem_pkg::MAG_FIX:  state_next = gpem_pkg::MAG_SQX;
            gpem_pkg::MAG_SQX:  state_next = gpem_pkg::MAG_SQY;
            gpem_pkg::MAG_SQY:  state_next = gpem_pkg::MAG_ROOT;
            gpem_pkg::MAG_ROOT:
            begin
                if (root_last)
                begin
                    state_next = gpem_pkg::MAG_IDLE;
                end
            end
            default: state_next = gpem_pkg::MAG_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            gpem_pkg::MAG_IDLE:
            begin
                if (start)
                begin
                    gx_reg    <= $signed(req.gx);
                    gy_reg    <= $signed(req.gy);
                    fix_x_reg <= req.fix_x;
                    fix_y_reg <= req.fix_y;
                end
            end
            gpem_pkg::MAG_FIX:
            begin
                if (fix_x_reg)
                begin
                    gx_reg <= rem3(gx_reg);
                end
                if (fix_y_reg)
                begin
                    gy_reg <= rem3(gy_reg);
                end
            end
            gpem_pkg::MAG_SQX:
            begin
                sq_reg <= gpem_pkg::SQ_W'(prod);
            end
            gpem_pkg::MAG_SQY:
            begin
                sq_reg   <= sq_reg + gpem_pkg::SQ_W'(prod);
                root_reg <= 8'd0;
                bit_reg  <= 3'd7;
            end
            gpem_pkg::MAG_ROOT:
            begin
                if (big)
                begin
                    root_reg <= 8'hFF;
                end
                else if (trial_sq <= sq_reg[15:0])
                begin
                    root_reg <= trial;
                end
                bit_reg <= bit_reg - 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign value = root_reg;

endmodule
